// ----- src/rlb_pkg.sv -----
// Shared types, constants and codes for the per-client rate limiter.
// No dependencies; every other file of the block uses this package.
package rlb_pkg;

    // Table geometry: a power of two, up to the client index range
    localparam int ENTRIES  = 1024;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CLIENT_W = 10;

    // Field widths
    localparam int TIME_W     = 32;
    localparam int LIMIT_W    = 16;
    localparam int WIN_W      = 17;
    localparam int FAIL_W     = 8;
    localparam int RESET_AT_W = 33;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Fixed offsets
    localparam logic [RESET_AT_W-1:0] RESET_OFFSET = RESET_AT_W'(3600);
    localparam logic [TIME_W-1:0]     BAN_SPAN_MAX = TIME_W'(131071);

    // Reset values of the registers
    localparam logic [LIMIT_W-1:0] AUTH_LIMIT_RST    = LIMIT_W'(5);
    localparam logic [LIMIT_W-1:0] GLOBAL_LIMIT_RST  = LIMIT_W'(1000);
    localparam logic [WIN_W-1:0]   AUTH_WINDOW_RST   = WIN_W'(60);
    localparam logic [WIN_W-1:0]   GLOBAL_WINDOW_RST = WIN_W'(3600);
    localparam logic [FAIL_W-1:0]  MAX_FAILURES_RST  = FAIL_W'(5);
    localparam logic [WIN_W-1:0]   BAN_SECONDS_RST   = WIN_W'(900);

    typedef enum logic {
        OP_ADMIT  = 1'b0,
        OP_RECORD = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        V_ALLOW    = 2'd0,
        V_BANNED   = 2'd1,
        V_OVER     = 2'd2,
        V_RECORDED = 2'd3
    } t_verdict;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AUTH_LIMIT    = 3'd0,
        REG_GLOBAL_LIMIT  = 3'd1,
        REG_AUTH_WINDOW   = 3'd2,
        REG_GLOBAL_WINDOW = 3'd3,
        REG_MAX_FAILURES  = 3'd4,
        REG_BAN_SECONDS   = 3'd5
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic [LIMIT_W-1:0] auth_limit;
        logic [LIMIT_W-1:0] global_limit;
        logic [WIN_W-1:0]   auth_window;
        logic [WIN_W-1:0]   global_window;
        logic [FAIL_W-1:0]  max_failures;
        logic [WIN_W-1:0]   ban_seconds;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0]  win_start;
        logic [LIMIT_W-1:0] req_cnt;
        logic [FAIL_W-1:0]  failure_tally;
        logic [TIME_W-1:0]  ban_end;
        logic               ban_live;
    } t_entry;

    typedef struct packed {
        t_opcode             opcode;
        logic [IDX_W-1:0]    idx;
        logic                is_auth;
        logic                auth_failed;
        logic [TIME_W-1:0]   now_seconds;
    } t_req;

    typedef struct packed {
        t_verdict              verdict;
        logic [LIMIT_W-1:0]    remaining;
        logic [RESET_AT_W-1:0] reset_at;
        logic [FAIL_W-1:0]     failure_count;
        logic                  banned_now;
    } t_rsp;

    // Table access from the control sequencer
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
    } t_tbl_ctl;

endpackage

// ----- src/rlb_if.sv -----
// Valid/ready channel interfaces: request, response and register write.
// Depends on rlb_pkg for widths.
interface rlb_req_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [rlb_pkg::CLIENT_W-1:0] client_index;
    logic                         is_auth;
    logic                         auth_failed;
    logic [rlb_pkg::TIME_W-1:0]   now_seconds;

    modport source (output valid, opcode, client_index, is_auth, auth_failed, now_seconds,
                    input ready);
    modport sink   (input valid, opcode, client_index, is_auth, auth_failed, now_seconds,
                    output ready);
endinterface

interface rlb_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     verdict;
    logic [rlb_pkg::LIMIT_W-1:0]    remaining;
    logic [rlb_pkg::RESET_AT_W-1:0] reset_at;
    logic [rlb_pkg::FAIL_W-1:0]     failure_count;
    logic                           banned_now;

    modport source (output valid, verdict, remaining, reset_at, failure_count, banned_now,
                    input ready);
    modport sink   (input valid, verdict, remaining, reset_at, failure_count, banned_now,
                    output ready);
endinterface

interface rlb_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rlb_pkg::CFG_IDX_W-1:0]  index;
    logic [rlb_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/per_client_rate_limiter_with_ban_core.sv -----
// Top level of the per-client rate limiter with ban on failed logins.
// Depends on rlb_pkg, rlb_if, rlb_cfg, rlb_table and rlb_update.

// Each request word is accepted in ST_IDLE, where the client's entry is read
// from the table memory, and finished in ST_EXEC, where it is updated, written
// back and the response register loaded; a new word is only taken after the
// previous one is written back, since the table read is registered and the
// write-back must land before the next read. The response register lets a new
// request in while the previous response waits; a request only stalls in its
// update cycle when that register is still full. After reset the table is
// cleared by a sweep over all 1024 entries (one entry per cycle) during which no
// request is taken; register writes are taken at any time and should be made
// while the block is idle.
module per_client_rate_limiter_with_ban_core (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rlb_req_if.sink  i_req,
    rlb_rsp_if.source o_rsp,
    rlb_cfg_if.sink  i_cfg
);

    rlb_pkg::t_state    r_state;
    rlb_pkg::t_state    n_state;
    rlb_pkg::t_cfg      cfg;
    rlb_pkg::t_tbl_ctl  tbl_ctl;
    rlb_pkg::t_entry    rd_entry;
    rlb_pkg::t_entry    upd_entry;
    rlb_pkg::t_rsp      upd_rsp;
    logic               clear_done;
    rlb_pkg::t_req      r_req;
    rlb_pkg::t_rsp      r_out;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               req_ready;
    logic               req_take;
    logic               out_free;
    logic               exec_fire;

    rlb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    rlb_table u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (tbl_ctl),
        .o_rd_data    (rd_entry),
        .o_clear_done (clear_done)
    );

    rlb_update u_update (
        .i_req   (r_req),
        .i_entry (rd_entry),
        .i_cfg   (cfg),
        .o_entry (upd_entry),
        .o_rsp   (upd_rsp)
    );

    assign out_free = !r_out_valid || o_rsp.ready;
    assign req_take = req_ready && i_req.valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rlb_pkg::ST_CLEAR: begin
                if (clear_done) begin
                    n_state = rlb_pkg::ST_IDLE;
                end
            end
            rlb_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = rlb_pkg::ST_EXEC;
                end
            end
            rlb_pkg::ST_EXEC: begin
                if (out_free) begin
                    n_state = rlb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rlb_pkg::ST_CLEAR;
            end
        endcase
    end

    // state outputs
    always_comb begin
        req_ready = 1'b0;
        exec_fire = 1'b0;
        unique case (r_state)
            rlb_pkg::ST_IDLE: begin
                req_ready = 1'b1;
            end
            rlb_pkg::ST_EXEC: begin
                exec_fire = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rlb_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // table access: read on accept, write back when the update fires
    always_comb begin
        tbl_ctl.rd_en   = req_take;
        tbl_ctl.rd_addr = i_req.client_index[rlb_pkg::IDX_W-1:0];
        tbl_ctl.wr_en   = exec_fire;
        tbl_ctl.wr_addr = r_req.idx;
        tbl_ctl.wr_data = upd_entry;
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_req.opcode      <= rlb_pkg::t_opcode'(i_req.opcode);
            r_req.idx         <= i_req.client_index[rlb_pkg::IDX_W-1:0];
            r_req.is_auth     <= i_req.is_auth;
            r_req.auth_failed <= i_req.auth_failed;
            r_req.now_seconds <= i_req.now_seconds;
        end
    end

    // response register
    always_comb begin
        n_out_valid = r_out_valid;
        if (exec_fire) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_out <= upd_rsp;
        end
    end

    assign i_req.ready         = req_ready;
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.verdict       = r_out.verdict;
    assign o_rsp.remaining     = r_out.remaining;
    assign o_rsp.reset_at      = r_out.reset_at;
    assign o_rsp.failure_count = r_out.failure_count;
    assign o_rsp.banned_now    = r_out.banned_now;

endmodule

// ----- src/rlb_cfg.sv -----
// Configuration register bank, written through the register write channel.
// Depends on rlb_pkg and rlb_cfg_if.
module rlb_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rlb_cfg_if.sink           i_cfg,
    output rlb_pkg::t_cfg     o_cfg
);

    rlb_pkg::t_cfg r_cfg;

    // writes are always taken
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.auth_limit    <= rlb_pkg::AUTH_LIMIT_RST;
            r_cfg.global_limit  <= rlb_pkg::GLOBAL_LIMIT_RST;
            r_cfg.auth_window   <= rlb_pkg::AUTH_WINDOW_RST;
            r_cfg.global_window <= rlb_pkg::GLOBAL_WINDOW_RST;
            r_cfg.max_failures  <= rlb_pkg::MAX_FAILURES_RST;
            r_cfg.ban_seconds   <= rlb_pkg::BAN_SECONDS_RST;
        end else if (i_cfg.valid) begin
            unique case (rlb_pkg::t_cfg_reg'(i_cfg.index))
                rlb_pkg::REG_AUTH_LIMIT: begin
                    r_cfg.auth_limit <= i_cfg.data[rlb_pkg::LIMIT_W-1:0];
                end
                rlb_pkg::REG_GLOBAL_LIMIT: begin
                    r_cfg.global_limit <= i_cfg.data[rlb_pkg::LIMIT_W-1:0];
                end
                rlb_pkg::REG_AUTH_WINDOW: begin
                    r_cfg.auth_window <= i_cfg.data[rlb_pkg::WIN_W-1:0];
                end
                rlb_pkg::REG_GLOBAL_WINDOW: begin
                    r_cfg.global_window <= i_cfg.data[rlb_pkg::WIN_W-1:0];
                end
                rlb_pkg::REG_MAX_FAILURES: begin
                    r_cfg.max_failures <= i_cfg.data[rlb_pkg::FAIL_W-1:0];
                end
                rlb_pkg::REG_BAN_SECONDS: begin
                    r_cfg.ban_seconds <= i_cfg.data[rlb_pkg::WIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- src/rlb_table.sv -----
// Client table: one synchronous memory with a registered read port and a
// clearing sweep after reset. Depends on rlb_pkg.
module rlb_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rlb_pkg::t_tbl_ctl   i_ctl,
    output rlb_pkg::t_entry     o_rd_data,
    output logic                o_clear_done
);

    rlb_pkg::t_entry                 mem [rlb_pkg::ENTRIES];
    rlb_pkg::t_entry                 r_rd_data;
    logic [rlb_pkg::IDX_W-1:0]       r_clr_addr;
    logic                            r_clr_done;

    assign o_rd_data    = r_rd_data;
    assign o_clear_done = r_clr_done;

    // clearing sweep, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_done <= 1'b0;
        end else if (!r_clr_done) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == rlb_pkg::IDX_W'(rlb_pkg::ENTRIES - 1)) begin
                r_clr_done <= 1'b1;
            end
        end
    end

    // write port: sweep has priority, sequencer writes only after it
    always_ff @(posedge i_clk) begin
        if (!r_clr_done) begin
            mem[r_clr_addr] <= '0;
        end else if (i_ctl.wr_en) begin
            mem[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= mem[i_ctl.rd_addr];
        end
    end

endmodule

// ----- src/rlb_update.sv -----
// Entry update: ban test, window restart, limit check, request and failure
// counting, and the response word. Depends on rlb_pkg.
module rlb_update (
    input  rlb_pkg::t_req    i_req,
    input  rlb_pkg::t_entry  i_entry,
    input  rlb_pkg::t_cfg    i_cfg,
    output rlb_pkg::t_entry  o_entry,
    output rlb_pkg::t_rsp    o_rsp
);

    logic [rlb_pkg::TIME_W-1:0]  ban_left;
    logic                        banned;
    logic [rlb_pkg::WIN_W-1:0]   win;
    logic [rlb_pkg::LIMIT_W-1:0] limit;
    logic [rlb_pkg::TIME_W-1:0]  age;
    logic                        expired;
    rlb_pkg::t_entry             adm_ent;
    rlb_pkg::t_entry             rec_ent;
    rlb_pkg::t_entry             nxt;
    rlb_pkg::t_verdict           adm_verdict;
    logic                        rec_ban;

    // ban test and window selection
    assign ban_left = i_entry.ban_end - i_req.now_seconds;
    assign banned   = i_entry.ban_live && (ban_left != '0) &&
                      (ban_left <= rlb_pkg::BAN_SPAN_MAX);
    assign win      = i_req.is_auth ? i_cfg.auth_window : i_cfg.global_window;
    assign limit    = i_req.is_auth ? i_cfg.auth_limit : i_cfg.global_limit;
    assign age      = i_req.now_seconds - i_entry.win_start;
    assign expired  = age > rlb_pkg::TIME_W'(win);

    // admit path: a banned entry stays untouched
    always_comb begin
        adm_ent = i_entry;
        if (!banned) begin
            adm_ent.ban_live = 1'b0;
            if (expired) begin
                adm_ent.win_start = i_req.now_seconds;
                adm_ent.req_cnt   = '0;
            end
        end
        if (banned) begin
            adm_verdict = rlb_pkg::V_BANNED;
        end else if (adm_ent.req_cnt < limit) begin
            adm_verdict = rlb_pkg::V_ALLOW;
        end else begin
            adm_verdict = rlb_pkg::V_OVER;
        end
    end

    // record path: saturating counts, ban once the tally reaches the limit
    always_comb begin
        rec_ent = i_entry;
        rec_ban = 1'b0;
        if (i_entry.req_cnt != '1) begin
            rec_ent.req_cnt = i_entry.req_cnt + 1'b1;
        end
        if (i_req.is_auth && i_req.auth_failed) begin
            if (i_entry.failure_tally != '1) begin
                rec_ent.failure_tally = i_entry.failure_tally + 1'b1;
            end
            if (rec_ent.failure_tally >= i_cfg.max_failures) begin
                rec_ent.ban_end  = i_req.now_seconds + rlb_pkg::TIME_W'(i_cfg.ban_seconds);
                rec_ent.ban_live = 1'b1;
                rec_ban          = 1'b1;
            end
        end else begin
            rec_ent.failure_tally = '0;
        end
    end

    // pick the path and build the response from the updated entry
    always_comb begin
        if (i_req.opcode == rlb_pkg::OP_RECORD) begin
            nxt               = rec_ent;
            o_rsp.verdict     = rlb_pkg::V_RECORDED;
            o_rsp.banned_now  = rec_ban;
        end else begin
            nxt               = adm_ent;
            o_rsp.verdict     = adm_verdict;
            o_rsp.banned_now  = 1'b0;
        end
        o_rsp.remaining     = (i_cfg.global_limit > nxt.req_cnt) ?
                              (i_cfg.global_limit - nxt.req_cnt) : '0;
        o_rsp.reset_at      = rlb_pkg::RESET_AT_W'(nxt.win_start) + rlb_pkg::RESET_OFFSET;
        o_rsp.failure_count = nxt.failure_tally;
    end

    assign o_entry = nxt;

endmodule

// ----- src/rlb_checker.sv -----
// Port-level checks for the rate limiter top level, attached by bind.
// Depends on rlb_pkg and per_client_rate_limiter_with_ban_core.
module rlb_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_req_valid,
    input logic                           i_req_ready,
    input logic                           i_rsp_valid,
    input logic                           i_rsp_ready,
    input logic [1:0]                     i_verdict,
    input logic [rlb_pkg::LIMIT_W-1:0]    i_remaining,
    input logic [rlb_pkg::RESET_AT_W-1:0] i_reset_at,
    input logic [rlb_pkg::FAIL_W-1:0]     i_failure_count,
    input logic                           i_banned_now
);

    // a stalled response word holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_verdict) &&
        $stable(i_remaining) && $stable(i_reset_at) && $stable(i_failure_count) &&
        $stable(i_banned_now))
        else $error("response word changed while stalled");

    // one request in the update stage at a time
    a_one_in_flight: assert property (@(posedge i_clk)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken back to back");

    // table sweep keeps requests out right after reset
    a_reset_blocks: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req_ready)
        else $error("request ready during table clear");

    // a new ban only comes from a record with a nonzero tally
    a_ban_on_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_banned_now |->
        (i_verdict == rlb_pkg::V_RECORDED) && (i_failure_count != '0))
        else $error("ban flag on a response that cannot set one");

endmodule

bind per_client_rate_limiter_with_ban_core rlb_checker u_rlb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_verdict       (o_rsp.verdict),
    .i_remaining     (o_rsp.remaining),
    .i_reset_at      (o_rsp.reset_at),
    .i_failure_count (o_rsp.failure_count),
    .i_banned_now    (o_rsp.banned_now)
);

// ----- sim/rlb_sb_pkg.sv -----
// Scoreboard for the per-client rate limiter: tracks the client table and registers.
// Depends on rlb_pkg for field widths, codes and reset values.
package rlb_sb_pkg;
    import rlb_pkg::*;

    class limiter_scoreboard;
        t_cfg   regs;
        t_entry slots [ENTRIES];
        t_rsp   awaited [$];
        int     errors;

        function new();
            regs.auth_limit    = AUTH_LIMIT_RST;
            regs.global_limit  = GLOBAL_LIMIT_RST;
            regs.auth_window   = AUTH_WINDOW_RST;
            regs.global_window = GLOBAL_WINDOW_RST;
            regs.max_failures  = MAX_FAILURES_RST;
            regs.ban_seconds   = BAN_SECONDS_RST;
            foreach (slots[i]) slots[i] = '0;
            errors = 0;
        endfunction

        // Register write, masked to the register's width
        function void set_reg(t_cfg_reg r, logic [CFG_DATA_W-1:0] v);
            case (r)
                REG_AUTH_LIMIT:    regs.auth_limit    = v[LIMIT_W-1:0];
                REG_GLOBAL_LIMIT:  regs.global_limit  = v[LIMIT_W-1:0];
                REG_AUTH_WINDOW:   regs.auth_window   = v[WIN_W-1:0];
                REG_GLOBAL_WINDOW: regs.global_window = v[WIN_W-1:0];
                REG_MAX_FAILURES:  regs.max_failures  = v[FAIL_W-1:0];
                REG_BAN_SECONDS:   regs.ban_seconds   = v[WIN_W-1:0];
                default: ;
            endcase
        endfunction

        // Apply one accepted request word to the table and queue the response it yields
        function void note_request(t_req w);
            t_entry             e;
            t_rsp               r;
            logic [TIME_W-1:0]  ban_left;
            logic [TIME_W-1:0]  since_start;
            logic [WIN_W-1:0]   win;
            logic [LIMIT_W-1:0] lim;
            e = slots[w.idx];
            r = '0;
            if (w.opcode == OP_ADMIT) begin
                ban_left = e.ban_end - w.now_seconds;
                if (e.ban_live && ban_left != '0 && ban_left <= BAN_SPAN_MAX) begin
                    // banned: entry stays as it is
                    r.verdict = V_BANNED;
                end else begin
                    e.ban_live  = 1'b0;
                    win         = w.is_auth ? regs.auth_window : regs.global_window;
                    lim         = w.is_auth ? regs.auth_limit : regs.global_limit;
                    since_start = w.now_seconds - e.win_start;
                    if (since_start > TIME_W'(win)) begin
                        e.win_start = w.now_seconds;
                        e.req_cnt   = '0;
                    end
                    r.verdict = (e.req_cnt < lim) ? V_ALLOW : V_OVER;
                end
            end else begin
                if (e.req_cnt != '1)
                    e.req_cnt = e.req_cnt + 1'b1;
                if (w.is_auth && w.auth_failed) begin
                    if (e.failure_tally != '1)
                        e.failure_tally = e.failure_tally + 1'b1;
                    // every failure at or past the limit restarts the ban
                    if (e.failure_tally >= regs.max_failures) begin
                        e.ban_end    = w.now_seconds + TIME_W'(regs.ban_seconds);
                        e.ban_live   = 1'b1;
                        r.banned_now = 1'b1;
                    end
                end else begin
                    e.failure_tally = '0;
                end
                r.verdict = V_RECORDED;
            end
            slots[w.idx] = e;
            r.remaining = (regs.global_limit > e.req_cnt) ?
                          regs.global_limit - e.req_cnt : '0;
            r.reset_at = {1'b0, e.win_start} + RESET_OFFSET;
            r.failure_count = e.failure_tally;
            awaited.push_back(r);
        endfunction

        function void compare_field(string name, logic [RESET_AT_W-1:0] want,
                                    logic [RESET_AT_W-1:0] got, realtime t);
            if (got !== want) begin
                errors++;
                $display("%0.3f ns: %s expected 0x%0h, got 0x%0h", t, name, want, got);
            end
        endfunction

        // Compare one accepted response word with the oldest expectation
        function void check_response(t_rsp got, realtime t);
            t_rsp want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0.3f ns: response expected none, got verdict %0d", t, got.verdict);
                return;
            end
            want = awaited.pop_front();
            compare_field("verdict", RESET_AT_W'(want.verdict), RESET_AT_W'(got.verdict), t);
            compare_field("remaining", RESET_AT_W'(want.remaining), RESET_AT_W'(got.remaining),
                          t);
            compare_field("reset_at", want.reset_at, got.reset_at, t);
            compare_field("failure_count", RESET_AT_W'(want.failure_count),
                          RESET_AT_W'(got.failure_count), t);
            compare_field("banned_now", RESET_AT_W'(want.banned_now),
                          RESET_AT_W'(got.banned_now), t);
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

endpackage

// ----- sim/tb_per_client_rate_limiter_with_ban_core.sv -----
// Testbench of per_client_rate_limiter_with_ban_core: directed and random request words
// under random back-pressure, checked against a table model. Depends on rlb_pkg,
// rlb_if, rlb_sb_pkg and the block's RTL.
module tb_per_client_rate_limiter_with_ban_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rlb_pkg::*;
    import rlb_sb_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SAT_WORDS   = 260;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rlb_req_if req_ch ();
    rlb_rsp_if rsp_ch ();
    rlb_cfg_if cfg_ch ();

    per_client_rate_limiter_with_ban_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    limiter_scoreboard sb;

    logic [TIME_W-1:0] wall_s = '0;
    int unsigned       words_sent = 0;
    int unsigned       cycle_count = 0;
    int unsigned       stall_left = 0;
    int unsigned       hot_clients [6];
    bit                send_gaps = 1'b1;
    bit                take_gaps = 1'b1;

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Response back-pressure in random bursts
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
        end else if (take_gaps && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 15);
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Response monitor
    always @(posedge i_clk) begin : rsp_mon
        t_rsp got;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.verdict       = t_verdict'(rsp_ch.verdict);
            got.remaining     = rsp_ch.remaining;
            got.reset_at      = rsp_ch.reset_at;
            got.failure_count = rsp_ch.failure_count;
            got.banned_now    = rsp_ch.banned_now;
            sb.check_response(got, $realtime);
        end
    end

    // One request word; starts and ends at a falling edge, valid left high
    task automatic send_word(t_opcode op, int unsigned idx, bit auth, bit failed,
                             logic [TIME_W-1:0] now);
        t_req w;
        w.opcode      = op;
        w.idx         = idx[IDX_W-1:0];
        w.is_auth     = auth;
        w.auth_failed = failed;
        w.now_seconds = now;
        if (send_gaps && $urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.opcode       <= op;
        req_ch.client_index <= idx[CLIENT_W-1:0];
        req_ch.is_auth      <= auth;
        req_ch.auth_failed  <= failed;
        req_ch.now_seconds  <= now;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        sb.note_request(w);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg r, int unsigned v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= r;
        cfg_ch.data  <= v[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        sb.set_reg(r, v[CFG_DATA_W-1:0]);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every response is back
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic load_regs(int unsigned a_lim, int unsigned g_lim, int unsigned a_win,
                             int unsigned g_win, int unsigned max_f, int unsigned ban_s);
        drain();
        write_reg(REG_AUTH_LIMIT, a_lim);
        write_reg(REG_GLOBAL_LIMIT, g_lim);
        write_reg(REG_AUTH_WINDOW, a_win);
        write_reg(REG_GLOBAL_WINDOW, g_win);
        write_reg(REG_MAX_FAILURES, max_f);
        write_reg(REG_BAN_SECONDS, ban_s);
    endtask

    function automatic int unsigned pick_client();
        if ($urandom_range(0, 6) == 0)
            return $urandom_range(0, ENTRIES - 1);
        return hot_clients[$urandom_range(0, 5)];
    endfunction

    // Move time on: mostly small steps, sometimes right at a window edge or far away
    function automatic void advance_clock();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            wall_s += $urandom_range(0, 2);
        else if (pick < 16)
            wall_s += $urandom_range(3, 70);
        else if (pick == 16)
            wall_s = wall_s + TIME_W'(sb.regs.auth_window) + $urandom_range(0, 2) - 1;
        else if (pick == 17)
            wall_s = wall_s + TIME_W'(sb.regs.global_window) + $urandom_range(0, 2) - 1;
        else if (pick == 18)
            wall_s += $urandom_range(1000, 140000);
        else
            wall_s = $urandom();
    endfunction

    // Admit then record, as a served request would
    task automatic serve_request();
        int unsigned c;
        bit          auth;
        c = pick_client();
        auth = ($urandom_range(0, 2) == 0);
        send_word(OP_ADMIT, c, auth, 1'($urandom_range(0, 1)), wall_s);
        advance_clock();
        send_word(OP_RECORD, c, auth,
                  auth ? ($urandom_range(0, 4) < 3) : 1'($urandom_range(0, 1)), wall_s);
        advance_clock();
    endtask

    // Repeated failed logins, then probes around the end of the ban
    task automatic login_storm();
        int unsigned c;
        int unsigned tries;
        c = pick_client();
        tries = $urandom_range(1, 10);
        repeat (tries) begin
            send_word(OP_ADMIT, c, 1'b1, 1'b0, wall_s);
            send_word(OP_RECORD, c, 1'b1, 1'b1, wall_s);
            if ($urandom_range(0, 2) == 0)
                wall_s += 1;
        end
        send_word(OP_ADMIT, c, 1'($urandom_range(0, 1)), 1'b0, wall_s);
        if ($urandom_range(0, 1) == 0)
            wall_s = wall_s + TIME_W'(sb.regs.ban_seconds) + $urandom_range(0, 2) - 1;
        send_word(OP_ADMIT, c, 1'b1, 1'b0, wall_s);
        if ($urandom_range(0, 1) == 0)
            send_word(OP_RECORD, c, 1'b1, 1'b0, wall_s);
    endtask

    // Random traffic until the phase's share of words has been sent
    task automatic random_phase(int unsigned share);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = words_sent + share;
        hot_clients[0] = 0;
        hot_clients[1] = ENTRIES - 1;
        for (int i = 2; i < 6; i++) hot_clients[i] = $urandom_range(0, ENTRIES - 1);
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 15) == 0) begin
                send_gaps = ($urandom_range(0, 3) != 0);
                take_gaps = ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                serve_request();
            end else if (pick < 8) begin
                login_storm();
            end else if (pick == 8) begin
                // noise: any field value at all
                send_word(t_opcode'($urandom_range(0, 1)), $urandom_range(0, ENTRIES - 1),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
            end else begin
                // broken sequence: record with no admit
                send_word(OP_RECORD, pick_client(), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), wall_s);
                advance_clock();
            end
        end
    endtask

    initial begin : main
        int unsigned sat_client;
        sb = new();
        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.opcode       = 1'b0;
        req_ch.client_index = '0;
        req_ch.is_auth      = 1'b0;
        req_ch.auth_failed  = 1'b0;
        req_ch.now_seconds  = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words with reset register values
        send_word(OP_ADMIT, 0, 1'b0, 1'b0, 32'd0);
        send_word(OP_RECORD, ENTRIES - 1, 1'b0, 1'b0, 32'hFFFF_FFFF);
        // window restart at the top of time: reset_at carries into bit 32
        send_word(OP_ADMIT, ENTRIES - 1, 1'b1, 1'b0, 32'hFFFF_FFFF);
        // failed logins up to the ban
        repeat (5) send_word(OP_RECORD, 5, 1'b1, 1'b1, 32'd100);
        send_word(OP_ADMIT, 5, 1'b0, 1'b0, 32'd100);
        // ban over exactly at its end time
        send_word(OP_ADMIT, 5, 1'b1, 1'b0, 32'd1000);
        // another failure past the limit bans again
        send_word(OP_RECORD, 5, 1'b1, 1'b1, 32'd1001);
        // failed flag on a non-auth record clears the tally
        send_word(OP_RECORD, 5, 1'b0, 1'b1, 32'd1001);
        send_word(OP_ADMIT, 5, 1'b1, 1'b0, 32'd1001);
        // auth limit reached
        send_word(OP_ADMIT, 7, 1'b1, 1'b0, 32'd200);
        repeat (5) send_word(OP_RECORD, 7, 1'b1, 1'b0, 32'd200);
        send_word(OP_ADMIT, 7, 1'b1, 1'b0, 32'd200);
        send_word(OP_ADMIT, 7, 1'b0, 1'b0, 32'd200);

        wall_s = 32'd500;
        random_phase(240);
        load_regs(3, 6, 10, 40, 2, 25);
        random_phase(240);
        load_regs(1, 1, 1, 1, 1, 1);
        random_phase(240);
        load_regs(65535, 65535, 131071, 131071, 255, 131071);
        random_phase(240);
        // zero registers: limits reject all, windows restart on any move, instant bans
        load_regs(0, 0, 0, 0, 0, 0);
        random_phase(150);
        load_regs($urandom_range(1, 12), $urandom_range(1, 64), $urandom_range(1, 200),
                  $urandom_range(1, 86400), $urandom_range(1, 8), $urandom_range(1, 86400));
        random_phase(240);

        // Last part, no idling: drive one client's failure tally into saturation
        send_gaps = 1'b0;
        take_gaps = 1'b0;
        load_regs(5, 65535, 131071, 131071, 255, 2);
        sat_client = $urandom_range(0, ENTRIES - 1);
        repeat (SAT_WORDS) send_word(OP_RECORD, sat_client, 1'b1, 1'b1, wall_s);
        send_word(OP_ADMIT, sat_client, 1'b0, 1'b0, wall_s);
        send_word(OP_RECORD, sat_client, 1'b1, 1'b0, wall_s);

        drain();
        repeat (8) @(negedge i_clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/rlb_pkg.sv
src/rlb_if.sv
src/rlb_cfg.sv
src/rlb_table.sv
src/rlb_update.sv
src/per_client_rate_limiter_with_ban_core.sv
src/rlb_checker.sv
sim/rlb_sb_pkg.sv
sim/tb_per_client_rate_limiter_with_ban_core.sv
